FILE: rtl/core/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
`timescale 1ns / 1ps

package ptrs_pkg;

  // Fixed field widths of the channel beats.
  localparam int OP_W     = 3;
  localparam int SLOT_IN_W = 4;
  localparam int DATA_W   = 16;
  localparam int RS_W     = 3;
  localparam int CNT_W    = $clog2(DATA_W);

  // Command codes carried in the op field.
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } rem_req_t;

  // Response from the shared remainder unit.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

FILE: rtl/core/ptrs_chan_if.sv
// Valid/ready channel interfaces for command beats and release beats.
`timescale 1ns / 1ps

interface ptrs_in_if;
  import ptrs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [SLOT_IN_W-1:0] slot;
  logic [DATA_W-1:0]    period;

  modport source (output valid, op, slot, period, input ready);
  modport sink   (input valid, op, slot, period, output ready);
endinterface

interface ptrs_out_if;
  import ptrs_pkg::*;
  logic            valid;
  logic            ready;
  logic [RS_W-1:0] released_slot;
  logic            last;

  modport source (output valid, released_slot, last, input ready);
  modport sink   (input valid, released_slot, last, output ready);
endinterface

FILE: rtl/core/ptrs_rem_unit.sv
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module ptrs_rem_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrs_pkg::rem_req_t  req,
  output ptrs_pkg::rem_rsp_t  rsp
);
  import ptrs_pkg::*;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_step;
  logic              last_step;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial    = {rem_r, dvd_r[DATA_W-1]};
    diff     = trial - {1'b0, div_r};
    rem_step = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
    last_step = busy_r && (cnt_r == CNT_W'(DATA_W - 1));
  end

  // Sequencing of the iterations.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      dvd_nxt = {dvd_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  // The response is valid in the cycle of the final step.
  assign rsp.done = last_step;
  assign rsp.zero = (rem_step == '0);

endmodule

FILE: rtl/core/periodic_task_release_scheduler.sv
// Top level: slot table, scan sequencer and release beat output register.
// A command beat (create, suspend, resume, delete) is applied while idle.
// A tick scans the slots in order, waits on the shared bit-serial remainder
// unit for each enabled slot with a nonzero period, then emits one release
// beat per due slot as the output side takes them, or returns to idle when
// nothing is due.
// The last beat of a tick may wait in the output register while the next
// command beat is taken.
// Synchronous active-low reset clears the counter and all slots.
`timescale 1ns / 1ps

module periodic_task_release_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  ptrs_in_if.sink  in_bus,
  ptrs_out_if.source out_bus
);
  import ptrs_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_t                 state_r, state_nxt;
  logic [DATA_W-1:0]      tick_r, tick_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_COUNT-1:0]  due_r, due_nxt;
  logic [SLOT_COUNT-1:0]  present_r, present_nxt;
  logic [SLOT_COUNT-1:0]  susp_r, susp_nxt;
  logic [DATA_W-1:0]      period_r [SLOT_COUNT];
  logic [DATA_W-1:0]      period_nxt [SLOT_COUNT];
  logic                   out_valid_r, out_valid_nxt;
  logic [RS_W-1:0]        out_slot_r, out_slot_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   slot_ok;
  logic [SLOT_W-1:0]      cmd_idx;
  logic                   eligible;
  logic                   idx_last;
  logic [SLOT_W-1:0]      first_idx;
  logic                   found;
  logic [SLOT_COUNT-1:0]  due_rest;
  rem_req_t               rem_req;
  rem_rsp_t               rem_rsp;

  // Shared remainder unit: tick count modulo a slot period.
  ptrs_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Handshake and command decode helpers.
  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_acc       = in_bus.valid && (state_r == ST_IDLE);
  assign slot_ok      = ({1'b0, in_bus.slot} < (SLOT_IN_W + 1)'(SLOT_COUNT));
  assign cmd_idx      = SLOT_W'(in_bus.slot);
  assign eligible     = present_r[idx_r] && !susp_r[idx_r] && (period_r[idx_r] != '0);
  assign idx_last     = (idx_r == SLOT_W'(SLOT_COUNT - 1));

  assign rem_req.start    = (state_r == ST_SCAN) && eligible;
  assign rem_req.dividend = tick_r;
  assign rem_req.divisor  = period_r[idx_r];

  // Lowest pending release in slot order.
  always_comb begin
    first_idx = '0;
    found     = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (due_r[i] && !found) begin
        first_idx = SLOT_W'(i);
        found     = 1'b1;
      end
    end
    due_rest = due_r & ~(SLOT_COUNT'(1) << first_idx);
  end

  // Sequencer and slot table updates.
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    due_nxt       = due_r;
    present_nxt   = present_r;
    susp_nxt      = susp_r;
    period_nxt    = period_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_bus.op == OP_TICK) begin
            tick_nxt  = tick_r + DATA_W'(1);
            idx_nxt   = '0;
            due_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if (slot_ok) begin
            case (in_bus.op)
              OP_CREATE: begin
                if (!present_r[cmd_idx]) begin
                  period_nxt[cmd_idx]  = in_bus.period;
                  present_nxt[cmd_idx] = 1'b1;
                  susp_nxt[cmd_idx]    = 1'b0;
                end
              end
              OP_SUSPEND: susp_nxt[cmd_idx] = 1'b1;
              OP_RESUME:  susp_nxt[cmd_idx] = 1'b0;
              OP_DELETE:  present_nxt[cmd_idx] = 1'b0;
              default: ;
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (eligible) begin
          state_nxt = ST_DIV;
        end else if (idx_last) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          due_nxt[idx_r] = rem_rsp.zero;
          if (idx_last) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_EMIT: begin
        if (!found) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = RS_W'(first_idx);
          out_last_nxt  = (due_rest == '0);
          due_nxt       = due_rest;
          if (due_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and slot state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      idx_r       <= '0;
      due_r       <= '0;
      present_r   <= '0;
      susp_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        period_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      due_r       <= due_nxt;
      present_r   <= present_nxt;
      susp_r      <= susp_nxt;
      out_valid_r <= out_valid_nxt;
      period_r    <= period_nxt;
    end
  end

  // Release beat payload.
  always_ff @(posedge clk) begin
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.released_slot = out_slot_r;
  assign out_bus.last          = out_last_r;

  // The remainder unit only finishes while the sequencer waits on it.
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == ST_DIV))
    else $error("remainder result outside of division wait");

  // A command beat other than a tick never starts a scan.
  a_cmd_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_bus.op != OP_TICK)) |=> (state_r == ST_IDLE))
    else $error("command beat left the idle state");

  // A release beat that is not the last of its tick means more are pending.
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> ((state_r == ST_EMIT) && (due_r != '0)))
    else $error("non-final release with nothing pending");

  // A scan never starts while an earlier tick still has undelivered releases.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !(out_valid_r && !out_last_r))
    else $error("scan overlaps pending releases");

endmodule
